### sv/byte_to_text_encoder_with_wrap_assert.svh
// Assertion macros used by the checker file.
`ifndef BYTE_TO_TEXT_ENCODER_WITH_WRAP_ASSERT_SVH
`define BYTE_TO_TEXT_ENCODER_WITH_WRAP_ASSERT_SVH

// Checked only while out of reset.
`define B2T_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define B2T_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/b2t_pkg.sv
`timescale 1ns / 1ps
package b2t_pkg;

  localparam logic [1:0] MODE_HEX      = 2'd0;
  localparam logic [1:0] MODE_BITS_LSB = 2'd1;
  localparam logic [1:0] MODE_BITS_MSB = 2'd2;
  localparam logic [1:0] MODE_Z85      = 2'd3;

  localparam logic       REG_MODE = 1'b0;
  localparam logic       REG_WRAP = 1'b1;

  localparam logic [1:0]  MODE_RESET = MODE_Z85;
  localparam logic [15:0] WRAP_RESET = 16'd76;

  localparam logic [7:0] CHAR_NL   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  // floor(v / 85) == (v * Z85_RECIP) >> Z85_SHIFT for every 32-bit v
  localparam logic [31:0] Z85_RECIP = 32'd3233857729;
  localparam int unsigned Z85_SHIFT = 38;
  localparam int unsigned Z85_DIGITS = 5;

  localparam int unsigned CMD_DEPTH_DEF = 2;
  localparam int unsigned RES_DEPTH_DEF = 2;

  localparam logic [16*8-1:0] HEX_CHARS = "0123456789ABCDEF";
  localparam logic [85*8-1:0] Z85_CHARS =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  typedef enum logic [2:0] {
    K_HEX,
    K_BITS_LSB,
    K_BITS_MSB,
    K_Z85,
    K_ERR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] data;
    logic        eom;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } res_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return HEX_CHARS[(4'd15 - nib) * 8 +: 8];
  endfunction

  function automatic logic [7:0] z85_char(input logic [6:0] dig);
    return Z85_CHARS[(7'd84 - dig) * 8 +: 8];
  endfunction

endpackage

### sv/b2t_fifo.sv
`timescale 1ns / 1ps
module b2t_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/b2t_front.sv
`timescale 1ns / 1ps
module b2t_front
  import b2t_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_push_i,
  output logic       in_full_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  input  logic [1:0] mode_i,
  input  logic       cmd_full_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  logic [23:0] group_q, group_d;
  logic [1:0]  fill_q, fill_d;
  logic        accept;

  assign in_full_o = cmd_full_i;
  assign accept    = in_push_i && !cmd_full_i;

  always_comb begin
    group_d    = group_q;
    fill_d     = fill_q;
    cmd_push_o = 1'b0;
    cmd_o.kind = K_HEX;
    cmd_o.data = {24'd0, data_byte_i};
    cmd_o.eom  = end_of_message_i;
    if (accept) begin
      case (mode_i) inside
        MODE_HEX, MODE_BITS_LSB, MODE_BITS_MSB: begin
          cmd_push_o = 1'b1;
          case (mode_i)
            MODE_BITS_LSB: cmd_o.kind = K_BITS_LSB;
            MODE_BITS_MSB: cmd_o.kind = K_BITS_MSB;
            default:       cmd_o.kind = K_HEX;
          endcase
          // leftover Z85 bytes are dropped silently at end of message
          if (end_of_message_i) begin
            group_d = '0;
            fill_d  = '0;
          end
        end
        default: begin
          if (fill_q != 2'd3) begin
            group_d = {group_q[15:0], data_byte_i};
            fill_d  = fill_q + 2'd1;
            if (end_of_message_i) begin
              cmd_push_o = 1'b1;
              cmd_o.kind = K_ERR;
              group_d    = '0;
              fill_d     = '0;
            end
          end else begin
            cmd_push_o = 1'b1;
            cmd_o.kind = K_Z85;
            cmd_o.data = {group_q, data_byte_i};
            group_d    = '0;
            fill_d     = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      fill_q  <= '0;
    end else begin
      group_q <= group_d;
      fill_q  <= fill_d;
    end
  end

endmodule

### sv/b2t_back.sv
`timescale 1ns / 1ps
module b2t_back
  import b2t_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  logic [15:0] wrap_width_i,
  input  logic        res_full_i,
  output logic        res_push_o,
  output res_t        res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_EMIT,
    ST_FINAL,
    ST_ERR
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] col_q, col_d;
  logic [2:0]  idx_q, idx_d;
  logic [2:0]  dcnt_q, dcnt_d;

  cmd_t        cmd_q;
  logic [31:0] v_q;
  logic [25:0] quo_q;
  logic [6:0]  dig_q [Z85_DIGITS];

  logic [63:0] prod;
  logic [31:0] quo_ext, quo_x85, rem;
  logic        ww_nz, wrap_hit, at_last;
  logic [2:0]  last_idx;
  logic [7:0]  cur_char;
  logic [7:0]  byte_v;

  assign prod    = v_q * Z85_RECIP;
  assign quo_ext = {6'd0, quo_q};
  // times 85 as shifts: 64 + 16 + 4 + 1
  assign quo_x85 = (quo_ext << 6) + (quo_ext << 4) + (quo_ext << 2) + quo_ext;
  assign rem     = v_q - quo_x85;

  assign ww_nz    = (wrap_width_i != '0);
  assign wrap_hit = ww_nz && (col_q >= wrap_width_i);
  assign byte_v   = cmd_q.data[7:0];

  always_comb begin
    case (cmd_q.kind)
      K_HEX:   last_idx = 3'd1;
      K_Z85:   last_idx = 3'(Z85_DIGITS - 1);
      default: last_idx = 3'd7;
    endcase
  end

  assign at_last = (idx_q == last_idx);

  always_comb begin
    case (cmd_q.kind)
      K_HEX:      cur_char = hex_char(idx_q[0] ? byte_v[3:0] : byte_v[7:4]);
      K_BITS_LSB: cur_char = byte_v[idx_q] ? CHAR_ONE : CHAR_ZERO;
      K_BITS_MSB: cur_char = byte_v[3'd7 - idx_q] ? CHAR_ONE : CHAR_ZERO;
      K_Z85:      cur_char = z85_char(dig_q[idx_q]);
      default:    cur_char = 8'h00;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    idx_d      = idx_q;
    dcnt_d     = dcnt_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.ch   = CHAR_NL;
    res_o.last = 1'b0;
    res_o.err  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          idx_d  = '0;
          dcnt_d = '0;
          case (cmd_i.kind)
            K_Z85:   state_d = ST_MUL;
            K_ERR:   state_d = ST_ERR;
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_MUL: begin
        state_d = ST_SUB;
      end
      ST_SUB: begin
        if (dcnt_q == 3'(Z85_DIGITS - 1)) begin
          state_d = ST_EMIT;
        end else begin
          dcnt_d  = dcnt_q + 3'd1;
          state_d = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (wrap_hit) begin
            col_d = '0;
          end else begin
            res_o.ch   = cur_char;
            res_o.last = at_last && !(cmd_q.eom && ww_nz);
            col_d      = (col_q == 16'hFFFF) ? col_q : col_q + 16'd1;
            if (at_last) begin
              if (cmd_q.eom && ww_nz) begin
                state_d = ST_FINAL;
              end else begin
                if (cmd_q.eom) begin
                  col_d = '0;
                end
                state_d = ST_IDLE;
              end
            end else begin
              idx_d = idx_q + 3'd1;
            end
          end
        end
      end
      ST_FINAL: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.last = 1'b1;
          col_d      = '0;
          state_d    = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.ch   = 8'h00;
          res_o.last = 1'b1;
          res_o.err  = 1'b1;
          col_d      = '0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      idx_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
      dcnt_q  <= dcnt_d;
    end
  end

  // digits come out least significant first, stored so index 0 is the MSD
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
      v_q   <= cmd_i.data;
    end
    if (state_q == ST_MUL) begin
      quo_q <= prod[63:Z85_SHIFT];
    end
    if (state_q == ST_SUB) begin
      dig_q[3'(Z85_DIGITS - 1) - dcnt_q] <= rem[6:0];
      v_q                                <= quo_ext;
    end
  end

endmodule

### sv/byte_to_text_encoder_with_wrap.sv
`timescale 1ns / 1ps
// Byte to text encoder: hex, bit strings or Z85, with optional line wrap.
// Input queue side: drive data_byte_i / end_of_message_i with push; a beat
// is taken when push is high and full is low. Result queue side: while
// empty is low the oldest character sits on out_char_o, last_of_run_o and
// length_error_o; pop takes it. Registers over APB: 0x0 mode, 0x4 wrap
// width; write only while no message is in flight.
// A beat goes through the command queue and the back end sequencer into
// the result queue; a completed Z85 group also passes the digit unit.
// The sequencer takes one command at a time in its idle state, then
// emits one character per cycle while the result queue is not full: two
// per byte in hex, eight for bit strings, five per group of four bytes in
// Z85 once the digit unit has done one multiply and one subtract per
// digit. Each wrap newline and final newline is an extra character.
// Reset empties both queues, clears column and group state, and sets mode
// to Z85 with a wrap width of 76.
// A stalled receiver fills the result queue; the back end then holds, the
// command queue fills and full rises until pop resumes.
module byte_to_text_encoder_with_wrap
  import b2t_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_message_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char_o,
  output logic        last_of_run_o,
  output logic        length_error_o
);

  logic [1:0]  mode_q;
  logic [15:0] wrap_q;
  logic        cfg_wr;

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  res_t res_in, res_out;
  logic res_push, res_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_WRAP) ? {16'd0, wrap_q} : {30'd0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
      wrap_q <= WRAP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MODE) begin
        mode_q <= pwdata[1:0];
      end else begin
        wrap_q <= pwdata[15:0];
      end
    end
  end

  b2t_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_push_i        (push),
    .in_full_o        (full),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .mode_i           (mode_q),
    .cmd_full_i       (cmd_full),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd_in)
  );

  b2t_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  b2t_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!cmd_empty),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .wrap_width_i (wrap_q),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  b2t_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign out_char_o     = res_out.ch;
  assign last_of_run_o  = res_out.last;
  assign length_error_o = res_out.err;

endmodule

### sv/b2t_checker.sv
`timescale 1ns / 1ps
`include "byte_to_text_encoder_with_wrap_assert.svh"
module b2t_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char_o,
  input logic       last_of_run_o,
  input logic       length_error_o
);

  logic       res_wait;
  logic       err_beat;
  logic       err_ok;
  logic       chr_beat;
  logic [9:0] res_beat;

  assign res_wait = !empty && !pop;
  assign err_beat = !empty && length_error_o;
  assign err_ok   = (out_char_o == 8'h00) && last_of_run_o;
  assign chr_beat = !empty && !length_error_o;
  assign res_beat = {out_char_o, last_of_run_o, length_error_o};

  // both queues come out of reset empty
  `B2T_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> empty && !full, "queue busy in reset")

  // an error beat ends its run and carries no character
  `B2T_ASSERT(a_err_shape, clk_i, rst_ni, err_beat |-> err_ok, "bad error beat")

  // every regular beat carries a non-null character
  `B2T_ASSERT(a_char_nonzero, clk_i, rst_ni, chr_beat |-> out_char_o != 8'h00, "null character")

  // a waiting result holds until popped
  `B2T_ASSERT(a_res_hold, clk_i, rst_ni, res_wait |=> !empty && $stable(res_beat), "beat moved")

endmodule

bind byte_to_text_encoder_with_wrap b2t_checker u_b2t_checker (.*);
